// ===== hw/rtl/zztr_pkg.sv =====
`timescale 1ns / 1ps

package zztr_pkg;

	// default sample width, signed Q16.16
	localparam int SAMPLE_WIDTH_DEF = 32;

	// direction codes, two bit two's complement
	localparam logic signed [1:0] DIR_NONE = 2'sb00;
	localparam logic signed [1:0] DIR_UP   = 2'sb01;
	localparam logic signed [1:0] DIR_DOWN = 2'sb11;

	// start-up phase of the tracker
	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_ONE  = 2'd1,
		PH_RUN  = 2'd2
	} phase_t;

	// control part of the tracker state
	typedef struct packed {
		phase_t           phase;
		logic signed [1:0] trend;
	} ctrl_t;

endpackage

// ===== hw/rtl/zztr_step.sv =====
`timescale 1ns / 1ps

module zztr_step #(
	parameter int SAMPLE_WIDTH = zztr_pkg::SAMPLE_WIDTH_DEF
) (
	input  zztr_pkg::ctrl_t                 ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0]  last_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]  extreme,
	input  logic signed [SAMPLE_WIDTH+1:0]  level,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample,
	input  logic        [SAMPLE_WIDTH-2:0]  margin,
	input  logic                            missing,
	output zztr_pkg::ctrl_t                 ctrl_d,
	output logic signed [SAMPLE_WIDTH-1:0]  last_sample_d,
	output logic signed [SAMPLE_WIDTH-1:0]  extreme_d,
	output logic signed [SAMPLE_WIDTH+1:0]  level_d
);
	import zztr_pkg::*;

	localparam int LW = SAMPLE_WIDTH + 2;

	logic signed [LW-1:0] s_x;
	logic signed [LW-1:0] mg_x;
	logic signed [LW-1:0] up_level;
	logic signed [LW-1:0] down_level;
	logic                 gt_last;
	logic                 lt_last;

	// widened sample and margin, level candidates
	assign s_x        = LW'(sample);
	assign mg_x       = $signed({3'b000, margin});
	assign up_level   = s_x - mg_x;
	assign down_level = s_x + mg_x;
	assign gt_last    = sample > last_sample;
	assign lt_last    = sample < last_sample;

	// next state for one word
	always_comb begin
		ctrl_d        = ctrl;
		last_sample_d = last_sample;
		extreme_d     = extreme;
		level_d       = level;
		if (!missing) begin
			unique case (ctrl.phase)
				PH_WAIT: begin
					ctrl_d.phase = PH_ONE;
					ctrl_d.trend = DIR_NONE;
				end
				PH_ONE: begin
					ctrl_d.phase = PH_RUN;
					if (gt_last) begin
						ctrl_d.trend = DIR_UP;
						extreme_d    = sample;
						level_d      = up_level;
					end else if (lt_last) begin
						ctrl_d.trend = DIR_DOWN;
						extreme_d    = sample;
						level_d      = down_level;
					end else begin
						ctrl_d.trend = DIR_NONE;
						extreme_d    = sample;
						level_d      = s_x;
					end
				end
				PH_RUN: begin
					case (ctrl.trend)
						DIR_DOWN: begin
							if (sample <= extreme) begin
								extreme_d = sample;
								level_d   = down_level;
							end else if (s_x >= level) begin
								ctrl_d.trend = DIR_UP;
								extreme_d    = sample;
								level_d      = up_level;
							end
						end
						DIR_UP: begin
							if (sample >= extreme) begin
								extreme_d = sample;
								level_d   = up_level;
							end else if (s_x <= level) begin
								ctrl_d.trend = DIR_DOWN;
								extreme_d    = sample;
								level_d      = down_level;
							end
						end
						default: begin
							// no direction yet: wait for a differing sample
							if (gt_last) begin
								ctrl_d.trend = DIR_UP;
								extreme_d    = sample;
								level_d      = up_level;
							end else if (lt_last) begin
								ctrl_d.trend = DIR_DOWN;
								extreme_d    = sample;
								level_d      = down_level;
							end
						end
					endcase
				end
				default: begin
					ctrl_d = ctrl;
				end
			endcase
			last_sample_d = sample;
		end
	end

endmodule

// ===== hw/rtl/zigzag_trend_reversal_core.sv =====
`timescale 1ns / 1ps

// zigzag trend reversal tracker
// input channel: in_valid / in_ready carry one word of sample (signed Q16.16),
// margin (unsigned Q15.16) and missing. output channel: out_valid / out_ready
// carry one word of direction (-1 down, 0 none yet, +1 up) for every input word.
// order: a word accepted is registered in the input stage; its direction is
// loaded into the output register once that register is free or drains.
// throughput: one word per cycle while out_ready is high; the state update is
// a single compare/add layer between input stage and state/output registers.
// reset: clears both pipeline stages and the tracker state (waiting for the
// first valid sample, no direction).
// stall: while out_ready is low the output word holds; the input stage still
// takes one more word if it is empty, then in_ready drops until the output
// drains. missing words hold the tracker state and repeat the direction.
module zigzag_trend_reversal_core #(
	parameter int SAMPLE_WIDTH = zztr_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic        [SAMPLE_WIDTH-2:0] margin,
	input  logic                           missing,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [1:0]              direction
);
	import zztr_pkg::*;

	// input stage
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic        [SAMPLE_WIDTH-2:0] margin_s1;
	logic                           missing_s1;

	// tracker state
	ctrl_t                          ctrl_q;
	logic signed [SAMPLE_WIDTH-1:0] last_q;
	logic signed [SAMPLE_WIDTH-1:0] extreme_q;
	logic signed [SAMPLE_WIDTH+1:0] level_q;

	// output register
	logic                           out_valid_q;
	logic signed [1:0]              direction_q;

	ctrl_t                          ctrl_d;
	logic signed [SAMPLE_WIDTH-1:0] last_d;
	logic signed [SAMPLE_WIDTH-1:0] extreme_d;
	logic signed [SAMPLE_WIDTH+1:0] level_d;
	logic                           advance;
	logic                           take;

	// handshake: stage 1 moves when the output register is free or drains
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign direction = direction_q;

	zztr_step #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_step (
		.ctrl          (ctrl_q),
		.last_sample   (last_q),
		.extreme       (extreme_q),
		.level         (level_q),
		.sample        (sample_s1),
		.margin        (margin_s1),
		.missing       (missing_s1),
		.ctrl_d        (ctrl_d),
		.last_sample_d (last_d),
		.extreme_d     (extreme_d),
		.level_d       (level_d)
	);

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1  <= sample;
			margin_s1  <= margin;
			missing_s1 <= missing;
		end
	end

	// tracker state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '{phase: PH_WAIT, trend: DIR_NONE};
			last_q      <= '0;
			extreme_q   <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
			direction_q <= DIR_NONE;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				ctrl_q      <= ctrl_d;
				last_q      <= last_d;
				extreme_q   <= extreme_d;
				level_q     <= level_d;
				direction_q <= ctrl_d.trend;
			end
		end
	end

	// only the three direction codes appear on the output
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (direction_q == DIR_NONE || direction_q == DIR_UP ||
			direction_q == DIR_DOWN))
		else $error("illegal direction code");

	// no direction before the running phase
	a_no_dir_early: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.phase != PH_RUN) |-> (ctrl_q.trend == DIR_NONE))
		else $error("direction set before running phase");

	// level sits behind the extreme in the direction of the trend
	a_level_up: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.trend == DIR_UP) |-> (level_q <= (SAMPLE_WIDTH + 2)'(extreme_q)))
		else $error("up trend level above extreme");

	a_level_down: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.trend == DIR_DOWN) |-> (level_q >= (SAMPLE_WIDTH + 2)'(extreme_q)))
		else $error("down trend level below extreme");

	// an empty input stage always takes a word
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage not ready");

endmodule

// ===== tb/zigzag_trend_reversal_core_tb.sv =====
`timescale 1ns / 1ps

module zigzag_trend_reversal_core_tb;
	import zztr_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int HOLD_CYCLES = 300;

	// tracks the trend the way the block should and checks each direction word
	class direction_board;
		phase_t                         run_phase;
		logic signed [SAMPLE_WIDTH_DEF-1:0] prev_sample;
		logic signed [SAMPLE_WIDTH_DEF-1:0] extreme;
		logic signed [SAMPLE_WIDTH_DEF+1:0] level;
		logic signed [1:0]              trend;
		logic signed [1:0]              expected_dirs[$];
		int                             mismatches;
		int                             checked;

		function new();
			run_phase = PH_WAIT;
			prev_sample = '0;
			extreme = '0;
			level = '0;
			trend = DIR_NONE;
			mismatches = 0;
			checked = 0;
		endfunction

		// new trend starts at this sample, level one margin behind it
		function void open_trend(input logic signed [1:0] dir,
				input logic signed [SAMPLE_WIDTH_DEF+1:0] s_w,
				input logic signed [SAMPLE_WIDTH_DEF+1:0] m_w);
			trend = dir;
			extreme = s_w[SAMPLE_WIDTH_DEF-1:0];
			level = (dir == DIR_UP) ? s_w - m_w : s_w + m_w;
		endfunction

		function logic signed [1:0] advance_trend(input logic signed [SAMPLE_WIDTH_DEF-1:0] smp,
				input logic [SAMPLE_WIDTH_DEF-2:0] mrg, input logic miss);
			logic signed [SAMPLE_WIDTH_DEF+1:0] s_w;
			logic signed [SAMPLE_WIDTH_DEF+1:0] m_w;
			s_w = smp;
			m_w = {3'b000, mrg};
			// missing words leave everything as it is
			if (!miss) begin
				case (run_phase)
					PH_WAIT: begin
						run_phase = PH_ONE;
						trend = DIR_NONE;
					end
					PH_ONE: begin
						run_phase = PH_RUN;
						if (smp > prev_sample)
							open_trend(DIR_UP, s_w, m_w);
						else if (smp < prev_sample)
							open_trend(DIR_DOWN, s_w, m_w);
						else begin
							trend = DIR_NONE;
							extreme = smp;
							level = s_w;
						end
					end
					default: begin
						if (trend == DIR_DOWN) begin
							// ties with the extreme extend it, ties with the level reverse
							if (smp <= extreme) begin
								extreme = smp;
								level = s_w + m_w;
							end else if (s_w >= level) begin
								open_trend(DIR_UP, s_w, m_w);
							end
						end else if (trend == DIR_UP) begin
							if (smp >= extreme) begin
								extreme = smp;
								level = s_w - m_w;
							end else if (s_w <= level) begin
								open_trend(DIR_DOWN, s_w, m_w);
							end
						end else begin
							// flat start: wait for a sample that differs
							if (smp > prev_sample)
								open_trend(DIR_UP, s_w, m_w);
							else if (smp < prev_sample)
								open_trend(DIR_DOWN, s_w, m_w);
						end
					end
				endcase
				prev_sample = smp;
			end
			return trend;
		endfunction

		function void note_word(input logic signed [SAMPLE_WIDTH_DEF-1:0] smp,
				input logic [SAMPLE_WIDTH_DEF-2:0] mrg, input logic miss);
			expected_dirs.push_back(advance_trend(smp, mrg, miss));
		endfunction

		task report_mismatch(input string what);
			$display("direction check failed at word %0d: %s", checked, what);
			mismatches++;
		endtask

		task check_direction(input logic signed [1:0] got);
			logic signed [1:0] want;
			if (expected_dirs.size() == 0) begin
				report_mismatch($sformatf("unexpected word, direction %0d", got));
			end else begin
				want = expected_dirs.pop_front();
				if (got !== want)
					report_mismatch($sformatf("got %0d, expected %0d", got, want));
			end
			checked++;
		endtask

		function int pending();
			return expected_dirs.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] sample = '0;
	logic        [SW-2:0] margin = '0;
	logic                 missing = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [1:0]    direction;

	direction_board       board;
	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   hold_trigger = 0;
	int                   hold_served = 0;
	int                   hold_left = 0;
	logic signed [SW-1:0] walk_value = '0;
	int                   walk_scale = 1 << 16;

	zigzag_trend_reversal_core #(
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.margin   (margin),
		.missing  (missing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.direction(direction)
	);

	// clock
	always #2 clk = ~clk;

	// offer one word after a random gap, return once it is taken
	task automatic send_word(input logic signed [SW-1:0] s, input logic [SW-2:0] m,
			input logic miss);
		int gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		margin <= m;
		missing <= miss;
		do @(posedge clk); while (!in_ready);
		board.note_word(s, m, miss);
	endtask

	// mostly random walks so that trends build and reverse, some noise and gaps
	task automatic random_words(input int count);
		int pick;
		int step;
		logic signed [SW-1:0] s;
		logic [SW-2:0] m;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				walk_scale = 1 << $urandom_range(0, 22);
			pick = $urandom_range(0, 99);
			if (pick < 7) begin
				send_word($urandom, (SW-1)'($urandom), 1'b1);
			end else if (pick < 15) begin
				s = $urandom;
				m = (SW-1)'($urandom);
				walk_value = s;
				send_word(s, m, 1'b0);
			end else begin
				step = (pick < 20) ? 0 : $urandom_range(0, 2 * walk_scale) - walk_scale;
				walk_value = walk_value + step;
				m = (SW-1)'($urandom_range(0, 3 * walk_scale));
				send_word(walk_value, m, 1'b0);
			end
		end
	endtask

	task automatic wait_drained();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// receiver: checks words and stalls at random or for a long hold
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				board.check_direction(direction);
			if (hold_trigger != hold_served) begin
				hold_served = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		#1_000_000;
		$display("zigzag_trend_reversal_core_tb: errors");
		$finish;
	end

	// main sequence
	initial begin
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 53;

		// leading missing words, first sample, flat start
		send_word({1'b0, {(SW-1){1'b1}}}, {(SW-1){1'b1}}, 1'b1);
		send_word({1'b1, {(SW-1){1'b0}}}, '0, 1'b1);
		send_word(32'sh0005_0000, 31'h0001_0000, 1'b0);
		send_word(32'sh0000_0000, 31'h0000_0000, 1'b1);
		send_word(32'sh0005_0000, 31'h0001_0000, 1'b0);
		send_word(32'sh0005_0000, 31'h0001_0000, 1'b0);
		// first differing sample starts a downtrend
		send_word(32'sh0004_0000, 31'h0002_0000, 1'b0);
		send_word(32'sh7fff_0000, 31'h7fff_ffff, 1'b1);
		// tie with the extreme, then tie with the level
		send_word(32'sh0004_0000, 31'h0003_0000, 1'b0);
		send_word(32'sh0007_0000, 31'h0000_0000, 1'b0);
		send_word(32'sh0007_0000, 31'h0000_0000, 1'b0);
		send_word(32'sh0006_ffff, 31'h0000_0000, 1'b0);
		// full scale swings with the widest margin
		send_word({1'b0, {(SW-1){1'b1}}}, {(SW-1){1'b1}}, 1'b0);
		send_word({1'b1, {(SW-1){1'b0}}}, {(SW-1){1'b1}}, 1'b0);
		send_word({1'b1, {(SW-1){1'b0}}}, {(SW-1){1'b1}}, 1'b0);
		send_word(-32'sd1, 31'h0000_0000, 1'b0);
		send_word({1'b0, {(SW-1){1'b1}}}, {(SW-1){1'b1}}, 1'b0);
		send_word(32'sh0000_0000, 31'h0000_0000, 1'b0);
		send_word(32'sh0000_0001, 31'h0000_0005, 1'b0);
		// alternating bit patterns
		send_word(32'sh5555_5555, 31'h2aaa_aaaa, 1'b0);
		send_word(32'shaaaa_aaaa, 31'h5555_5555, 1'b0);

		random_words(200);
		// long receiver hold while words keep coming
		hold_trigger++;
		random_words(250);
		in_valid <= 1'b0;
		wait_drained();

		send_idle_pct = 53;
		recv_idle_pct = 33;
		random_words(500);
		in_valid <= 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_words(530);
		in_valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("zigzag_trend_reversal_core_tb: clean");
		else
			$display("zigzag_trend_reversal_core_tb: errors");
		$finish;
	end

endmodule

// ===== zigzag_trend_reversal_core.f =====
hw/rtl/zztr_pkg.sv
hw/rtl/zztr_step.sv
hw/rtl/zigzag_trend_reversal_core.sv
tb/zigzag_trend_reversal_core_tb.sv
